// ----- sv/k_nearest_neighbor_lists_assert.svh -----
// Assertion macros for the k nearest neighbor list block.
// Used by k_nearest_neighbor_lists.sv; no other dependencies.
`ifndef K_NEAREST_NEIGHBOR_LISTS_ASSERT_SVH
`define K_NEAREST_NEIGHBOR_LISTS_ASSERT_SVH
`define KNN_ASSERT_IMPL(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("knn check failed");
`define KNN_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("knn check failed");
`endif

// ----- sv/knn_pkg.sv -----
// Shared types and constants for the k nearest neighbor list block.
// No dependencies.
package knn_pkg;
  localparam int MaxPoints    = 1024;
  localparam int MaxNeighbors = 64;
  localparam int CoordW       = 16;
  localparam int DistW        = 33;
  localparam int IdxW         = 10;
  localparam int RankW        = 6;
  localparam int NumPtsW      = 11;
  localparam int LimitW       = 7;
  localparam int NeighLimitRst = 50;

  localparam logic [0:0] REQ_LOAD  = 1'b0;
  localparam logic [0:0] REQ_QUERY = 1'b1;

  localparam int REG_NUM_POINTS     = 0;
  localparam int REG_NEIGHBOR_LIMIT = 1;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SELF  = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_EMIT  = 5'b01000,
    ST_CLR   = 5'b10000
  } state_t;
endpackage

// ----- sv/k_nearest_neighbor_lists.sv -----
// k nearest neighbor lists, top level.
// Depends on knn_pkg, knn_ram and k_nearest_neighbor_lists_assert.svh.
// A load is one transfer; busy stays low. A query with an in-range index and nonzero K
// reads the queried point, then streams the point store one entry per cycle through a
// three-stage pipeline (read, squares, sum) into a sorted list of K cells that takes one
// candidate per cycle. The K results follow one per cycle on out_valid, and the last
// result is shown in the final busy cycle. The receiver cannot stall.
`include "k_nearest_neighbor_lists_assert.svh"
module k_nearest_neighbor_lists #(
  parameter int MaxPoints    = knn_pkg::MaxPoints,
  parameter int MaxNeighbors = knn_pkg::MaxNeighbors
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_req_type,
  input  logic [knn_pkg::IdxW-1:0] in_point_index,
  input  logic signed [knn_pkg::CoordW-1:0] in_point_x,
  input  logic signed [knn_pkg::CoordW-1:0] in_point_y,
  output logic        out_valid,
  output logic [knn_pkg::IdxW-1:0]  out_neighbor_index,
  output logic [knn_pkg::DistW-1:0] out_distance_squared,
  output logic [knn_pkg::RankW-1:0] out_rank,
  output logic        out_last_of_list,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int AW = $clog2(MaxPoints);
  localparam int CW = $clog2(MaxNeighbors + 1);
  localparam int NW = $clog2(MaxPoints + 1);
  localparam int EW = knn_pkg::DistW + AW;
  localparam int CWD = 2 * knn_pkg::CoordW;

  // configuration
  logic [knn_pkg::NumPtsW-1:0] num_points_r;
  logic [knn_pkg::LimitW-1:0]  neighbor_limit_r;
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_points_r     <= knn_pkg::NumPtsW'(1);
      neighbor_limit_r <= knn_pkg::LimitW'(knn_pkg::NeighLimitRst);
    end else if (cfg_wr) begin
      if (32'(paddr[2]) == knn_pkg::REG_NUM_POINTS)
        num_points_r <= pwdata[knn_pkg::NumPtsW-1:0];
      else neighbor_limit_r <= pwdata[knn_pkg::LimitW-1:0];
    end
  end
  always_comb begin
    prdata = '0;
    if (32'(paddr[2]) == knn_pkg::REG_NUM_POINTS)
      prdata[knn_pkg::NumPtsW-1:0] = num_points_r;
    else prdata[knn_pkg::LimitW-1:0] = neighbor_limit_r;
  end

  // effective counts
  logic [NW-1:0] n_eff;
  logic [CW-1:0] lim_eff, k_eff;
  always_comb begin
    n_eff = (32'(num_points_r) > MaxPoints) ? NW'(MaxPoints) : NW'(num_points_r);
    lim_eff = (32'(neighbor_limit_r) > MaxNeighbors) ? CW'(MaxNeighbors)
                                                     : CW'(neighbor_limit_r);
    if (n_eff == '0) k_eff = '0;
    else if (32'(n_eff) - 1 < 32'(lim_eff)) k_eff = CW'(n_eff - NW'(1));
    else k_eff = lim_eff;
  end

  knn_pkg::state_t state_r, state_nxt;
  logic accept;
  assign busy   = (state_r != knn_pkg::ST_IDLE);
  assign accept = start && !busy;

  // point store
  logic          pt_we;
  logic [AW-1:0] pt_waddr, pt_raddr;
  logic [CWD-1:0] pt_rdata;
  logic in_range;
  assign in_range = (32'(in_point_index) < MaxPoints);
  assign pt_we    = accept && (in_req_type == knn_pkg::REQ_LOAD) && in_range;
  assign pt_waddr = AW'(in_point_index);

  knn_ram #(.Width(CWD), .Depth(MaxPoints)) u_pts (
    .clk(clk), .we(pt_we), .waddr(pt_waddr), .wdata({in_point_y, in_point_x}),
    .raddr(pt_raddr), .rdata(pt_rdata)
  );

  // query registers
  logic [AW-1:0] qi_r;
  logic [CWD-1:0] me_r;
  logic [CW-1:0] k_r, cnt_r, pos_r;
  logic [NW-1:0] n_r, rd_r;        // next store address to issue
  logic          v0_r, v1_r, v2_r; // pipeline valids
  logic [AW-1:0] j0_r, j1_r, j2_r;
  logic [CWD-1:0] sx_r, sy_r;
  logic [knn_pkg::DistW-1:0] d2_r;
  // sorted list cells {dist, idx}, nearest in cell 0
  logic [EW-1:0] key_r [MaxNeighbors];
  logic [EW-1:0] cand;
  assign cand = {d2_r, j2_r};

  // stage 1: differences squared
  logic signed [knn_pkg::CoordW:0] dx, dy;
  assign dx = {pt_rdata[knn_pkg::CoordW-1], pt_rdata[knn_pkg::CoordW-1:0]}
            - {me_r[knn_pkg::CoordW-1], me_r[knn_pkg::CoordW-1:0]};
  assign dy = {pt_rdata[CWD-1], pt_rdata[CWD-1:knn_pkg::CoordW]}
            - {me_r[CWD-1], me_r[CWD-1:knn_pkg::CoordW]};

  // insertion position: first cell whose key exceeds candidate
  logic [CW-1:0] pos_c;
  always_comb begin
    pos_c = cnt_r;
    for (int i = MaxNeighbors - 1; i >= 0; i--)
      if (CW'(i) < cnt_r && key_r[i] > cand) pos_c = CW'(i);
  end

  logic ins, issue;
  assign ins   = (state_r == knn_pkg::ST_SCAN) && v2_r && (pos_c < k_r);
  assign issue = (state_r == knn_pkg::ST_SCAN) && (rd_r < n_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      knn_pkg::ST_IDLE:
        if (accept && in_req_type == knn_pkg::REQ_QUERY && in_range && k_eff != '0)
          state_nxt = knn_pkg::ST_SELF;
      knn_pkg::ST_SELF: state_nxt = knn_pkg::ST_SCAN;
      knn_pkg::ST_SCAN:
        if (!v0_r && !v1_r && !v2_r && rd_r >= n_r) state_nxt = knn_pkg::ST_EMIT;
      knn_pkg::ST_EMIT:
        if (pos_r + CW'(1) == cnt_r) state_nxt = knn_pkg::ST_CLR;
      knn_pkg::ST_CLR: state_nxt = knn_pkg::ST_IDLE;
      default: state_nxt = knn_pkg::ST_IDLE;
    endcase
  end

  // read address
  assign pt_raddr = (state_r == knn_pkg::ST_IDLE) ? AW'(in_point_index) : AW'(rd_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= knn_pkg::ST_IDLE;
      v0_r <= 1'b0; v1_r <= 1'b0; v2_r <= 1'b0;
      cnt_r <= '0; pos_r <= '0; rd_r <= '0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        knn_pkg::ST_IDLE: begin
          qi_r  <= AW'(in_point_index);
          n_r   <= n_eff;
          k_r   <= k_eff;
          cnt_r <= '0;
          pos_r <= '0;
          rd_r  <= '0;
          v0_r <= 1'b0; v1_r <= 1'b0; v2_r <= 1'b0;
        end
        knn_pkg::ST_SELF: me_r <= pt_rdata;
        knn_pkg::ST_SCAN: begin
          // pipeline: issue -> v0 (data ready) -> v1 (squares) -> v2 (sum)
          v0_r <= issue;
          j0_r <= AW'(rd_r);
          if (issue) rd_r <= rd_r + NW'(1);
          v1_r <= v0_r && (j0_r != qi_r);
          j1_r <= j0_r;
          sx_r <= CWD'(dx * dx);
          sy_r <= CWD'(dy * dy);
          v2_r <= v1_r;
          j2_r <= j1_r;
          d2_r <= knn_pkg::DistW'(sx_r) + knn_pkg::DistW'(sy_r);
          if (ins && cnt_r < k_r) cnt_r <= cnt_r + CW'(1);
        end
        knn_pkg::ST_EMIT: pos_r <= pos_r + CW'(1);
        knn_pkg::ST_CLR: ;
        default: ;
      endcase
    end
  end

  // list cells: insert with shift toward the far end, shift toward cell 0 on emit
  always_ff @(posedge clk) begin
    for (int i = 0; i < MaxNeighbors; i++) begin
      if (ins) begin
        if (CW'(i) == pos_c) key_r[i] <= cand;
        else if (CW'(i) > pos_c) key_r[i] <= key_r[(i > 0) ? i - 1 : 0];
      end else if (state_r == knn_pkg::ST_EMIT) begin
        key_r[i] <= key_r[(i < MaxNeighbors - 1) ? i + 1 : i];
      end
    end
  end

  // result registers, loaded in the cycle after each emit state cycle
  logic emit_d_r;
  logic [EW-1:0] eout_r;
  logic [CW-1:0] epos_r;
  logic elast_r;
  always_ff @(posedge clk) begin
    if (!rst_n) emit_d_r <= 1'b0;
    else emit_d_r <= (state_r == knn_pkg::ST_EMIT);
  end
  always_ff @(posedge clk) begin
    eout_r  <= key_r[0];
    epos_r  <= pos_r;
    elast_r <= (pos_r + CW'(1) == cnt_r);
  end
  assign out_valid            = emit_d_r;
  assign out_neighbor_index   = knn_pkg::IdxW'(eout_r[AW-1:0]);
  assign out_distance_squared = eout_r[EW-1:AW];
  assign out_rank             = knn_pkg::RankW'(epos_r);
  assign out_last_of_list     = elast_r;

  `KNN_ASSERT_IMPL(a_cnt_le_k, busy, cnt_r <= k_r)
  `KNN_ASSERT_NEXT(a_emit_last, out_valid && out_last_of_list, !out_valid)
  `KNN_ASSERT_IMPL(a_out_busy, out_valid, busy)
  `KNN_ASSERT_IMPL(a_no_accept_busy, state_r == knn_pkg::ST_SCAN, busy)
endmodule

// ----- sv/knn_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module knn_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
